// ----- design/assert_macros.svh -----
// Assertion macros for the RTL of the token classifier; only the top level includes them.
// Each macro checks one implication on the rising edge of aclk, outside reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/ltc_pkg.sv -----
// Shared types, constants and helper functions of the token classifier.
// Used by ltc_front, ltc_queue, ltc_back and lexer_token_classifier; depends on nothing.
package ltc_pkg;

    // Field widths and limits.
    localparam int CHAR_W      = 8;
    localparam int KIND_W      = 5;
    localparam int LEN_W       = 8;
    localparam int MATCH_CHARS = 8;
    localparam int LENGTH_MAX  = 255;
    localparam int NUM_NAMES   = 18;
    localparam int NAME_LEN_W  = 4;
    localparam int NAME_TEXT_W = 64;
    localparam int S_TDATA_W   = 8;
    localparam int M_TDATA_W   = 16;

    // Token queue geometry.
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    // Characters with a special role.
    localparam logic [CHAR_W-1:0] CH_EQ    = 8'h3D;
    localparam logic [CHAR_W-1:0] CH_BANG  = 8'h21;
    localparam logic [CHAR_W-1:0] CH_QUOTE = 8'h22;

    // Token kind codes.
    localparam logic [KIND_W-1:0] KIND_ERROR    = 5'd0;
    localparam logic [KIND_W-1:0] KIND_TRUE     = 5'd1;
    localparam logic [KIND_W-1:0] KIND_FALSE    = 5'd2;
    localparam logic [KIND_W-1:0] KIND_NULL     = 5'd3;
    localparam logic [KIND_W-1:0] KIND_FUNCTION = 5'd4;
    localparam logic [KIND_W-1:0] KIND_RETURN   = 5'd5;
    localparam logic [KIND_W-1:0] KIND_VAR      = 5'd6;
    localparam logic [KIND_W-1:0] KIND_IDENT    = 5'd7;
    localparam logic [KIND_W-1:0] KIND_STRING   = 5'd8;
    localparam logic [KIND_W-1:0] KIND_NUMBER   = 5'd9;
    localparam logic [KIND_W-1:0] KIND_ASSIGN   = 5'd10;
    localparam logic [KIND_W-1:0] KIND_EQUAL    = 5'd11;
    localparam logic [KIND_W-1:0] KIND_NOT      = 5'd12;
    localparam logic [KIND_W-1:0] KIND_NOTEQ    = 5'd13;
    localparam logic [KIND_W-1:0] KIND_LBRACE   = 5'd14;
    localparam logic [KIND_W-1:0] KIND_RBRACE   = 5'd15;
    localparam logic [KIND_W-1:0] KIND_LPAREN   = 5'd16;
    localparam logic [KIND_W-1:0] KIND_RPAREN   = 5'd17;
    localparam logic [KIND_W-1:0] KIND_MINUS    = 5'd18;
    localparam logic [KIND_W-1:0] KIND_PLUS     = 5'd19;
    localparam logic [KIND_W-1:0] KIND_COMMA    = 5'd20;
    localparam logic [KIND_W-1:0] KIND_SEMI     = 5'd21;
    localparam logic [KIND_W-1:0] KIND_LAST     = KIND_SEMI;

    // First characters of the current word, entry k holds character k.
    typedef logic [MATCH_CHARS-1:0][CHAR_W-1:0] word_t;

    // One finished token as it travels to the output.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [LEN_W-1:0]  length;
        logic              last;
    } token_t;

    // Up to two tokens written into the queue in one cycle, tok0 first.
    typedef struct packed {
        logic [1:0] cnt;
        token_t     tok0;
        token_t     tok1;
    } push_t;

    // A keyword or operator; text is right-justified, last character lowest.
    typedef struct packed {
        logic [NAME_LEN_W-1:0]  len;
        logic [KIND_W-1:0]      kind;
        logic [NAME_TEXT_W-1:0] text;
    } name_t;

    localparam name_t NAMES [NUM_NAMES] = '{
        '{4'd4, KIND_TRUE,     64'("true")},
        '{4'd5, KIND_FALSE,    64'("false")},
        '{4'd4, KIND_NULL,     64'("null")},
        '{4'd8, KIND_FUNCTION, 64'("function")},
        '{4'd6, KIND_RETURN,   64'("return")},
        '{4'd3, KIND_VAR,      64'("var")},
        '{4'd1, KIND_ASSIGN,   64'("=")},
        '{4'd2, KIND_EQUAL,    64'("==")},
        '{4'd1, KIND_NOT,      64'("!")},
        '{4'd2, KIND_NOTEQ,    64'("!=")},
        '{4'd1, KIND_LBRACE,   64'("{")},
        '{4'd1, KIND_RBRACE,   64'("}")},
        '{4'd1, KIND_LPAREN,   64'("(")},
        '{4'd1, KIND_RPAREN,   64'(")")},
        '{4'd1, KIND_MINUS,    64'("-")},
        '{4'd1, KIND_PLUS,     64'("+")},
        '{4'd1, KIND_COMMA,    64'(",")},
        '{4'd1, KIND_SEMI,     64'(";")}
    };

    function automatic logic is_alpha(input logic [CHAR_W-1:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic is_digit(input logic [CHAR_W-1:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic is_alnum(input logic [CHAR_W-1:0] c);
        return is_alpha(c) || is_digit(c);
    endfunction

    // Printable, non-space and not a letter or digit.
    function automatic logic is_punct(input logic [CHAR_W-1:0] c);
        return c >= 8'h21 && c <= 8'h7E && !is_alnum(c);
    endfunction

    // Kind of a finished word: a keyword or operator match wins, otherwise
    // the first character decides. All name compares run in parallel.
    function automatic logic [KIND_W-1:0] classify(input word_t chars,
                                                   input logic [LEN_W-1:0] len,
                                                   input logic [CHAR_W-1:0] first);
        logic [KIND_W-1:0] kind;
        logic              found;
        logic              same;
        int                idx;
        if (is_alpha(first)) begin
            kind = KIND_IDENT;
        end else if (is_digit(first)) begin
            kind = KIND_NUMBER;
        end else if (first == CH_QUOTE) begin
            kind = KIND_STRING;
        end else begin
            kind = KIND_ERROR;
        end
        found = 1'b0;
        for (int i = 0; i < NUM_NAMES; i++) begin
            same = (len == LEN_W'(NAMES[i].len));
            for (int k = 0; k < MATCH_CHARS; k++) begin
                idx = (k < int'(NAMES[i].len)) ? CHAR_W * (int'(NAMES[i].len) - 1 - k) : 0;
                if (k < int'(NAMES[i].len) && chars[k] != NAMES[i].text[idx +: CHAR_W]) begin
                    same = 1'b0;
                end
            end
            if (same && !found) begin
                kind  = NAMES[i].kind;
                found = 1'b1;
            end
        end
        return kind;
    endfunction

endpackage

// ----- design/ltc_front.sv -----
// Front end of the token classifier: groups characters into words and
// classifies each finished word. Depends on ltc_pkg.
module ltc_front (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          accept,
    input  logic [ltc_pkg::CHAR_W-1:0]    ch,
    input  logic                          end_of_text,
    output ltc_pkg::push_t                push
);

    ltc_pkg::word_t                chars_reg;
    ltc_pkg::word_t                chars_next;
    logic [ltc_pkg::LEN_W-1:0]     len_reg;
    logic [ltc_pkg::LEN_W-1:0]     len_next;
    logic [ltc_pkg::CHAR_W-1:0]    first_reg;
    logic [ltc_pkg::CHAR_W-1:0]    first_next;

    logic [ltc_pkg::CHAR_W-1:0]    first_eff;
    logic                          grow;
    logic                          emit_a;
    logic                          emit_b;
    logic [ltc_pkg::LEN_W-1:0]     len_mid;
    ltc_pkg::token_t               tok_a;
    ltc_pkg::token_t               tok_b;

    // Word state after this character, before an end-of-text flush.
    always_comb begin
        first_eff = (len_reg == '0) ? ch : first_reg;
        grow = (ltc_pkg::is_alnum(first_eff) && ltc_pkg::is_alnum(ch)) ||
               (ltc_pkg::is_punct(first_eff) && ltc_pkg::is_punct(ch) &&
                (len_reg == '0 || first_eff == ltc_pkg::CH_EQ ||
                 first_eff == ltc_pkg::CH_BANG));
        chars_next = chars_reg;
        len_mid    = len_reg;
        first_next = first_eff;
        emit_a     = 1'b0;
        if (grow) begin
            for (int k = 0; k < ltc_pkg::MATCH_CHARS; k++) begin
                if (len_reg == ltc_pkg::LEN_W'(k)) begin
                    chars_next[k] = ch;
                end
            end
            if (len_reg < ltc_pkg::LEN_W'(ltc_pkg::LENGTH_MAX)) begin
                len_mid = len_reg + 1'b1;
            end
        end else if (len_reg != '0) begin
            // The character closes the pending word and may open a new one.
            emit_a  = 1'b1;
            len_mid = '0;
            if (ltc_pkg::is_alnum(ch) || ltc_pkg::is_punct(ch)) begin
                first_next    = ch;
                chars_next[0] = ch;
                len_mid       = ltc_pkg::LEN_W'(1);
            end
        end
        emit_b   = end_of_text && (len_mid != '0);
        len_next = emit_b ? '0 : len_mid;
    end

    // Tokens caused by this character, in output order.
    always_comb begin
        tok_a.kind   = ltc_pkg::classify(chars_reg, len_reg, first_reg);
        tok_a.length = len_reg;
        tok_a.last   = !emit_b;
        tok_b.kind   = ltc_pkg::classify(chars_next, len_mid, first_next);
        tok_b.length = len_mid;
        tok_b.last   = 1'b1;
        if (emit_a) begin
            push.tok0 = tok_a;
            push.tok1 = tok_b;
            push.cnt  = emit_b ? 2'd2 : 2'd1;
        end else begin
            push.tok0 = tok_b;
            push.tok1 = tok_b;
            push.cnt  = emit_b ? 2'd1 : 2'd0;
        end
        if (!accept) begin
            push.cnt = 2'd0;
        end
    end

    // Word buffer holds no reset value; only entries below the length are read.
    always_ff @(posedge aclk) begin
        if (accept) begin
            chars_reg <= chars_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg   <= '0;
            first_reg <= '0;
        end else if (accept) begin
            len_reg   <= len_next;
            first_reg <= first_next;
        end
    end

endmodule

// ----- design/ltc_queue.sv -----
// Short token queue between the front end and the output stage: takes up to
// two tokens per cycle and gives one. Depends on ltc_pkg.
module ltc_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  ltc_pkg::push_t  push,
    input  logic            pop,
    output logic            room,
    output logic            q_valid,
    output ltc_pkg::token_t q_data
);

    ltc_pkg::token_t                mem_reg [ltc_pkg::Q_DEPTH];
    logic [ltc_pkg::Q_PTR_W-1:0]    wr_ptr_reg;
    logic [ltc_pkg::Q_PTR_W-1:0]    wr_ptr_next;
    logic [ltc_pkg::Q_PTR_W-1:0]    rd_ptr_reg;
    logic [ltc_pkg::Q_PTR_W-1:0]    rd_ptr_next;
    logic [ltc_pkg::Q_CNT_W-1:0]    count_reg;
    logic [ltc_pkg::Q_CNT_W-1:0]    count_next;
    logic [ltc_pkg::Q_PTR_W-1:0]    wr_ptr_plus1;

    // A new character is taken only while two slots are free.
    assign room         = count_reg <= ltc_pkg::Q_CNT_W'(ltc_pkg::Q_DEPTH - 2);
    assign q_valid      = count_reg != '0;
    assign q_data       = mem_reg[rd_ptr_reg];
    assign wr_ptr_plus1 = wr_ptr_reg + 1'b1;

    // Pointer and fill count updates.
    always_comb begin
        wr_ptr_next = wr_ptr_reg + ltc_pkg::Q_PTR_W'(push.cnt);
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + ltc_pkg::Q_CNT_W'(push.cnt) -
                      ltc_pkg::Q_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Token storage.
    always_ff @(posedge aclk) begin
        if (push.cnt != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push.tok0;
        end
        if (push.cnt == 2'd2) begin
            mem_reg[wr_ptr_plus1] <= push.tok1;
        end
    end

endmodule

// ----- design/ltc_back.sv -----
// Output stage of the token classifier: moves tokens from the queue into the
// result register and holds them while the receiver stalls. Depends on ltc_pkg.
module ltc_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            q_valid,
    input  ltc_pkg::token_t                 q_data,
    output logic                            pop,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ltc_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                            m_tlast
);

    logic            valid_reg;
    logic            valid_next;
    ltc_pkg::token_t out_reg;

    // Load a token whenever the result register is empty or being taken.
    assign pop        = q_valid && (!valid_reg || m_tready);
    assign valid_next = pop || (valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            out_reg <= q_data;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {(ltc_pkg::M_TDATA_W - ltc_pkg::KIND_W - ltc_pkg::LEN_W)'(0),
                       out_reg.length, out_reg.kind};
    assign m_tlast  = out_reg.last;

endmodule

// ----- design/lexer_token_classifier.sv -----
// Top level of the token classifier: front end, token queue and output stage.
// Depends on ltc_pkg, ltc_front, ltc_queue, ltc_back and assert_macros.svh.
//
// Usage:
//   The s_ channel takes one character per transfer: s_tdata holds the
//   character, s_tlast marks the final character of the text, which flushes
//   the pending word. The m_ channel gives one token per transfer: kind and
//   length in m_tdata, m_tlast set on the last token caused by a character.
//   A character gives zero, one or two tokens.
//   A character is taken every cycle while the token queue has two free
//   slots. The queue is written at the edge that takes the character, and
//   the result register is loaded from it while that register is empty or
//   being taken; m_tvalid shows the result register. While the receiver is
//   ready the output stage gives one token per cycle, so the sustained rate
//   is one character per cycle while characters average at most one token.
//   When the receiver stalls, the result register holds its token, the
//   four-entry queue fills and s_tready drops until a slot pair is free.
//   Reset clears the word length, the queue and the result valid flag; the
//   block takes characters as soon as reset is released.
`include "assert_macros.svh"

module lexer_token_classifier (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ltc_pkg::S_TDATA_W-1:0]   s_tdata,   // [7:0] ch
    input  logic                            s_tlast,   // end_of_text
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ltc_pkg::M_TDATA_W-1:0]   m_tdata,   // [4:0] token_kind, [12:5] token_length
    output logic                            m_tlast    // last_of_run
);

    logic            accept;
    logic            room;
    logic            pop;
    logic            q_valid;
    ltc_pkg::push_t  push;
    ltc_pkg::token_t q_data;

    assign s_tready = room;
    assign accept   = s_tvalid && room;

    ltc_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .ch          (s_tdata[ltc_pkg::CHAR_W-1:0]),
        .end_of_text (s_tlast),
        .push        (push)
    );

    ltc_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .pop     (pop),
        .room    (room),
        .q_valid (q_valid),
        .q_data  (q_data)
    );

    ltc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Tokens enter the queue only on a character transfer.
    `ASSERT_SAME(a_push_on_accept, push.cnt != 2'd0, accept, "token pushed without a transfer")
    // With two tokens from one character only the second carries the last flag.
    `ASSERT_SAME(a_pair_last, push.cnt == 2'd2, !push.tok0.last && push.tok1.last,
                 "bad last flags on a token pair")
    // A single token from one character always closes its run.
    `ASSERT_SAME(a_single_last, push.cnt == 2'd1, push.tok0.last, "single token not last")
    // A delivered token has a known kind and a nonzero length.
    `ASSERT_SAME(a_out_token, m_tvalid,
                 m_tdata[12:5] != 8'd0 && m_tdata[4:0] <= ltc_pkg::KIND_LAST,
                 "malformed output token")

endmodule

// ----- dv/tb.sv -----
// Self-checking testbench for lexer_token_classifier: streams characters in, checks tokens out.
// Depends on ltc_pkg for field widths, kind codes and the token structure; needs only the RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TEXT_ITEMS  = 650;
    localparam int QUIET_TAIL  = 60;
    localparam int HOLD_AT     = 200;
    localparam int HOLD_CYCLES = 64;
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE      = 16;
    localparam int WORD_BITS   = ltc_pkg::CHAR_W * ltc_pkg::MATCH_CHARS;

    typedef struct {
        logic [ltc_pkg::CHAR_W-1:0] ch;
        logic                       eot;
        logic                       drain;   // wait for all tokens before sending
    } text_char_t;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [ltc_pkg::S_TDATA_W-1:0] s_tdata = '0;   // [7:0] ch
    logic              s_tlast  = 1'b0;   // end_of_text
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [ltc_pkg::M_TDATA_W-1:0] m_tdata;        // [4:0] token_kind, [12:5] token_length
    logic              m_tlast;           // last_of_run

    text_char_t       source_text [$];
    ltc_pkg::token_t  pending_tokens [$];

    // Shadow of the lexer state.
    logic [ltc_pkg::CHAR_W-1:0] word_buf [ltc_pkg::MATCH_CHARS];
    int unsigned                word_len = 0;
    logic [ltc_pkg::CHAR_W-1:0] lead_char = '0;

    int  errors = 0;
    int  chars_taken = 0;
    int  tokens_checked = 0;
    int  pair_chars = 0;
    int  saturated = 0;
    int  send_gap = 0;
    int  sink_gap = 0;
    int  hold_left = 0;
    bit  hold_done = 0;
    bit  drain_next = 0;
    int  quiet_cycles = 0;

    always #6 aclk = ~aclk;

    lexer_token_classifier dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // Character classes of the source language.
    function automatic bit is_letter(input logic [ltc_pkg::CHAR_W-1:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic bit is_numeral(input logic [ltc_pkg::CHAR_W-1:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic bit is_word_char(input logic [ltc_pkg::CHAR_W-1:0] c);
        return is_letter(c) || is_numeral(c);
    endfunction

    function automatic bit is_symbol(input logic [ltc_pkg::CHAR_W-1:0] c);
        return c >= 8'd33 && c <= 8'd126 && !is_word_char(c);
    endfunction

    // Kind of the word held in the shadow state. Words longer than the match
    // buffer never hit a keyword or operator.
    function automatic logic [ltc_pkg::KIND_W-1:0] word_kind();
        logic [WORD_BITS-1:0] text;
        text = '0;
        if (word_len <= ltc_pkg::MATCH_CHARS) begin
            for (int k = 0; k < word_len; k++) begin
                text = {text[WORD_BITS-ltc_pkg::CHAR_W-1:0], word_buf[k]};
            end
            case (text)
                WORD_BITS'("true"):     return ltc_pkg::KIND_TRUE;
                WORD_BITS'("false"):    return ltc_pkg::KIND_FALSE;
                WORD_BITS'("null"):     return ltc_pkg::KIND_NULL;
                WORD_BITS'("function"): return ltc_pkg::KIND_FUNCTION;
                WORD_BITS'("return"):   return ltc_pkg::KIND_RETURN;
                WORD_BITS'("var"):      return ltc_pkg::KIND_VAR;
                WORD_BITS'("="):        return ltc_pkg::KIND_ASSIGN;
                WORD_BITS'("=="):       return ltc_pkg::KIND_EQUAL;
                WORD_BITS'("!"):        return ltc_pkg::KIND_NOT;
                WORD_BITS'("!="):       return ltc_pkg::KIND_NOTEQ;
                WORD_BITS'("{"):        return ltc_pkg::KIND_LBRACE;
                WORD_BITS'("}"):        return ltc_pkg::KIND_RBRACE;
                WORD_BITS'("("):        return ltc_pkg::KIND_LPAREN;
                WORD_BITS'(")"):        return ltc_pkg::KIND_RPAREN;
                WORD_BITS'("-"):        return ltc_pkg::KIND_MINUS;
                WORD_BITS'("+"):        return ltc_pkg::KIND_PLUS;
                WORD_BITS'(","):        return ltc_pkg::KIND_COMMA;
                WORD_BITS'(";"):        return ltc_pkg::KIND_SEMI;
                default: ;
            endcase
        end
        if (is_letter(lead_char)) return ltc_pkg::KIND_IDENT;
        if (is_numeral(lead_char)) return ltc_pkg::KIND_NUMBER;
        if (lead_char == ltc_pkg::CH_QUOTE) return ltc_pkg::KIND_STRING;
        return ltc_pkg::KIND_ERROR;
    endfunction

    function automatic void append_char(input logic [ltc_pkg::CHAR_W-1:0] c);
        if (word_len < ltc_pkg::MATCH_CHARS) word_buf[word_len] = c;
        if (word_len < ltc_pkg::LENGTH_MAX) word_len++;
    endfunction

    function automatic ltc_pkg::token_t close_word();
        ltc_pkg::token_t tok;
        tok.kind   = word_kind();
        tok.length = word_len[ltc_pkg::LEN_W-1:0];
        tok.last   = 1'b0;
        if (word_len == ltc_pkg::LENGTH_MAX) saturated++;
        word_len = 0;
        return tok;
    endfunction

    // Advance the shadow lexer by one character and queue the tokens it finishes.
    task automatic lex_char(input logic [ltc_pkg::CHAR_W-1:0] c, input logic eot);
        ltc_pkg::token_t found [$];
        bit              grow;
        grow = 1'b0;
        if (word_len == 0) lead_char = c;
        if (is_word_char(lead_char) && is_word_char(c)) grow = 1'b1;
        if (is_symbol(lead_char) && is_symbol(c) &&
            (word_len == 0 || lead_char == ltc_pkg::CH_EQ ||
             lead_char == ltc_pkg::CH_BANG)) grow = 1'b1;
        if (grow) begin
            append_char(c);
        end else if (word_len > 0) begin
            found.push_back(close_word());
            if (is_word_char(c) || is_symbol(c)) begin
                lead_char = c;
                append_char(c);
            end
        end
        if (eot && word_len > 0) found.push_back(close_word());
        if (found.size() > 0) found[found.size()-1].last = 1'b1;
        if (found.size() == 2) pair_chars++;
        foreach (found[i]) pending_tokens.push_back(found[i]);
    endtask

    // Stimulus helpers.
    function automatic void put_char(input logic [ltc_pkg::CHAR_W-1:0] c, input logic eot);
        text_char_t item;
        item.ch    = c;
        item.eot   = eot;
        item.drain = drain_next;
        drain_next = 1'b0;
        source_text.push_back(item);
    endfunction

    function automatic void put_text(input string s);
        for (int i = 0; i < s.len(); i++) put_char(s[i], 1'b0);
    endfunction

    function automatic logic [ltc_pkg::CHAR_W-1:0] rand_letter();
        int n;
        n = $urandom_range(0, 51);
        return (n < 26) ? ltc_pkg::CHAR_W'("a" + n) : ltc_pkg::CHAR_W'("A" + n - 26);
    endfunction

    function automatic logic [ltc_pkg::CHAR_W-1:0] rand_alnum();
        int n;
        n = $urandom_range(0, 61);
        return (n < 52) ? rand_letter() : ltc_pkg::CHAR_W'("0" + n - 52);
    endfunction

    function automatic logic [ltc_pkg::CHAR_W-1:0] rand_symbol();
        logic [ltc_pkg::CHAR_W-1:0] c;
        c = ltc_pkg::CHAR_W'($urandom_range(33, 126));
        while (!is_symbol(c)) c = ltc_pkg::CHAR_W'($urandom_range(33, 126));
        return c;
    endfunction

    // One well-formed word with random content.
    task automatic queue_word();
        string kw [9] = '{"true", "false", "null", "function", "return", "var",
                          "identifier", "string", "number"};
        string ops = "=!{}()-+,;";
        string s;
        int    n;
        case ($urandom_range(0, 10))
            0, 1: begin
                put_text(kw[$urandom_range(0, 8)]);
            end
            2: begin
                // Near misses of a keyword: one character short or one too many.
                s = kw[$urandom_range(0, 5)];
                if ($urandom_range(0, 1)) begin
                    put_text(s);
                    put_char(rand_alnum(), 1'b0);
                end else begin
                    put_text(s.substr(0, s.len() - 2));
                end
            end
            3, 4: begin
                put_char(rand_letter(), 1'b0);
                n = $urandom_range(0, 11);
                repeat (n) put_char(rand_alnum(), 1'b0);
            end
            5: begin
                n = $urandom_range(1, 10);
                repeat (n) put_char(ltc_pkg::CHAR_W'("0" + $urandom_range(0, 9)), 1'b0);
                if ($urandom_range(0, 3) == 0) put_char(rand_letter(), 1'b0);
            end
            6: begin
                put_char(ltc_pkg::CH_QUOTE, 1'b0);
            end
            7, 8: begin
                put_char(ops[$urandom_range(0, 9)], 1'b0);
            end
            9: begin
                put_char($urandom_range(0, 1) ? ltc_pkg::CH_EQ : ltc_pkg::CH_BANG, 1'b0);
                if ($urandom_range(0, 2) != 0) put_char(ltc_pkg::CH_EQ, 1'b0);
                if ($urandom_range(0, 4) == 0) put_char(rand_symbol(), 1'b0);
            end
            default: begin
                n = $urandom_range(1, 3);
                repeat (n) put_char(rand_symbol(), 1'b0);
            end
        endcase
    endtask

    // Driver: offers the next character whenever the channel is free, apart from random gaps and drain points.
    always @(posedge aclk) begin : source_side
        text_char_t nxt;
        logic       taken;
        taken = s_tvalid && s_tready;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (taken) begin
                lex_char(s_tdata, s_tlast);
                chars_taken++;
            end
            if (!s_tvalid || taken) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_tvalid <= 1'b0;
                end else if (source_text.size() == 0 ||
                             (source_text[0].drain && pending_tokens.size() != 0)) begin
                    s_tvalid <= 1'b0;
                end else begin
                    nxt = source_text.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt.ch;
                    s_tlast  <= nxt.eot;
                    if (source_text.size() > QUIET_TAIL && hold_left == 0 &&
                        $urandom_range(0, 7) == 0) begin
                        send_gap = $urandom_range(1, 13);
                    end
                end
            end
        end
    end

    // Monitor: compares each token transfer with the oldest expected token.
    always @(posedge aclk) begin : sink_side
        ltc_pkg::token_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (pending_tokens.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected token kind %0d length %0d last %0b",
                             $time, m_tdata[4:0], m_tdata[12:5], m_tlast);
                end else begin
                    want = pending_tokens.pop_front();
                    tokens_checked++;
                    if (m_tdata[4:0] !== want.kind) begin
                        errors++;
                        $display("%0t: token_kind expected %0d, got %0d",
                                 $time, want.kind, m_tdata[4:0]);
                    end
                    if (m_tdata[12:5] !== want.length) begin
                        errors++;
                        $display("%0t: token_length expected %0d, got %0d",
                                 $time, want.length, m_tdata[12:5]);
                    end
                    if (m_tlast !== want.last) begin
                        errors++;
                        $display("%0t: last_of_run expected %0b, got %0b",
                                 $time, want.last, m_tlast);
                    end
                end
            end
            // One long hold-off lets the token queue fill and stall the input.
            if (!hold_done && chars_taken >= HOLD_AT) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if (source_text.size() > QUIET_TAIL && $urandom_range(0, 7) == 0) begin
                    sink_gap = $urandom_range(1, 13);
                end
            end
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: timeout, no transfer for %0d cycles, %0d tokens outstanding",
                     $time, quiet_cycles, pending_tokens.size());
            $display("lexer_token_classifier verification failed");
            $finish;
        end
    end

    initial begin
        bit long_done;
        int next_drain;
        long_done  = 1'b0;
        next_drain = 250;
        foreach (word_buf[i]) word_buf[i] = '0;

        // Directed text: extreme codes, a keyword closed by punctuation, a
        // final character giving two tokens, a lone quote, the not-equal
        // operator closed by DEL, and a keyword grown past the match buffer.
        put_char(8'h00, 1'b0);
        put_text("var");
        put_char("(", 1'b0);
        put_char(8'hFF, 1'b0);
        put_text("9z");
        put_char("=", 1'b1);
        put_char(ltc_pkg::CH_QUOTE, 1'b0);
        put_char("q", 1'b0);
        put_char(8'h80, 1'b0);
        put_text("!=");
        put_char(8'h7F, 1'b0);
        put_text("function");
        put_char("s", 1'b1);

        // Random text: mostly words and separators, some raw bytes, one word
        // long enough to saturate the length, and a few points where the
        // sender waits for the output to drain.
        drain_next = 1'b1;
        while (source_text.size() < TEXT_ITEMS) begin
            if (!long_done && source_text.size() >= 300) begin
                put_char(rand_letter(), 1'b0);
                repeat (259) put_char(rand_alnum(), 1'b0);
                put_char(" ", 1'b0);
                long_done = 1'b1;
            end else if ($urandom_range(0, 4) == 0) begin
                put_char(ltc_pkg::CHAR_W'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
            end else begin
                queue_word();
                case ($urandom_range(0, 5))
                    0: put_char(" ", 1'b0);
                    1: put_char(8'h0A, 1'b0);
                    2: put_char(8'h09, 1'b0);
                    3: put_char(ltc_pkg::CHAR_W'($urandom_range(128, 255)), 1'b0);
                    default: ;
                endcase
                if ($urandom_range(0, 11) == 0) source_text[source_text.size()-1].eot = 1'b1;
            end
            if (source_text.size() >= next_drain) begin
                drain_next = 1'b1;
                next_drain += 220;
            end
        end

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        wait (source_text.size() == 0 && !s_tvalid);
        wait (pending_tokens.size() == 0);
        repeat (SETTLE) @(posedge aclk);

        $display("Sent %0d characters and checked %0d tokens.", chars_taken, tokens_checked);
        $display("%0d characters gave two tokens; %0d tokens had a saturated length.",
                 pair_chars, saturated);
        if (errors == 0) begin
            $display("lexer_token_classifier verification clean");
        end else begin
            $display("lexer_token_classifier verification failed");
        end
        $finish;
    end
endmodule
